[rtl/hflp_pkg.sv]
// Package with request, status and state codes for the hashed FIFO.
package hflp_pkg;

  // Number of table slots; the result fields are sized for this table.
  localparam int SLOTS = 256;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_REM  = 2'd2,
    REQ_LOOK = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  localparam logic CFG_HASH_MODE = 1'b0;
  localparam logic CFG_MAX_FILL  = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] item_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [7:0]  slot_index;
    logic [8:0]  entry_count;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_HASH,
    S_HASH_W,
    S_HOME,
    S_PROBE_RD,
    S_PROBE,
    S_ENQ_WR,
    S_ENQ_LINK,
    S_DEQ_RD,
    S_DEQ_KEY,
    S_UNLINK_RD,
    S_UNLINK,
    S_UNLINK2,
    S_SH_RD,
    S_SH_KEY,
    S_SH_HASH,
    S_SH_HASH_W,
    S_SH_TEST,
    S_SH_MOVE,
    S_SH_FIXP,
    S_SH_FIXN,
    S_DONE
  } state_e;

  // Handshake between the sequencer and the hash unit.
  typedef struct packed {
    logic        start;
    logic [15:0] key;
    logic        mode;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] hash;
  } hash_rsp_t;

endpackage

[rtl/hflp_hash.sv]
// Multicycle hash unit: identity or FNV-1a over two octets folded to 16 bits.
module hflp_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hflp_pkg::hash_req_t req_i,
  output hflp_pkg::hash_rsp_t rsp_o
);

  logic [31:0] h_q, h_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        mode_q, mode_d;
  logic [15:0] key_q, key_d;
  logic [31:0] x;
  logic [31:0] prod;

  always_comb begin
    x = h_q ^ {24'd0, (step_q == 2'd0) ? key_q[7:0] : key_q[15:8]};
    prod = x * hflp_pkg::FNV_PRIME;
    h_d = h_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    key_d = key_q;
    if (req_i.start) begin
      key_d = req_i.key;
      mode_d = req_i.mode;
      h_d = hflp_pkg::FNV_BASIS;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!mode_q) begin
        h_d = {16'd0, key_q};
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (step_q == 2'd2) begin
        h_d = {16'd0, h_q[31:16] ^ h_q[15:0]};
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        h_d = prod;
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    mode_q <= mode_d;
    key_q <= key_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hash = h_q[15:0];

endmodule

[rtl/hashed_fifo_linear_probe.sv]
// Top level of the hashed FIFO with linear probing and backward-shift removal.
// A request is taken when start_i is high and busy_o is low; its single result
// shows on rsp_o with done_o high for one cycle and cannot be held off. The
// block serves one request at a time. A request waits on the hash unit for
// two FNV rounds plus fold in FNV mode or a plain copy of the key in identity
// mode. An enqueue passes over one occupied slot per cycle, a search reads and
// then compares each slot key through the registered read of the key memory,
// and removal walks slots in a backward shift that rehashes each slot key and
// moves every entry that may fill the gap, then mends its prev and next links.
// A request takes longer as the chain grows. Used bits are flip-flops cleared
// by reset, so no clearing pass is needed. Key, prev and next links live in
// memories with registered reads.
module hashed_fifo_linear_probe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  hflp_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output hflp_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [8:0]     cfg_data_i
);

  localparam int SLOTS = hflp_pkg::SLOTS;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Storage: keys and order links, plus per-slot used flags.
  logic [15:0]   key_mem [SLOTS];
  logic [AW-1:0] prv_mem [SLOTS];
  logic [AW-1:0] nxt_mem [SLOTS];
  logic [SLOTS-1:0] used_q, used_d;

  logic          hash_mode_q;
  logic [8:0]    max_fill_q;

  hflp_pkg::state_e state_q, state_d;
  logic [1:0]    req_q, req_d;
  logic [15:0]   id_q, id_d;
  logic [AW-1:0] s_q, s_d;        // probe slot / removed slot
  logic [AW-1:0] gap_q, gap_d;
  logic [AW-1:0] look_q, look_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] old_q, old_d;
  logic [AW-1:0] new_q, new_d;
  logic [15:0]   mkey_q, mkey_d;  // key of the entry being moved
  logic [AW-1:0] mprv_q, mprv_d;
  logic [AW-1:0] mnxt_q, mnxt_d;
  hflp_pkg::rsp_t rsp_q, rsp_d;
  logic          done_q, done_d;

  // Memory port controls.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   key_rd;
  logic [AW-1:0] prv_rd, nxt_rd;
  logic          kw_en, pw_en, nw_en;
  logic [AW-1:0] kw_addr, pw_addr, nw_addr;
  logic [15:0]   kw_data;
  logic [AW-1:0] pw_data, nw_data;

  hflp_pkg::hash_req_t hreq;
  hflp_pkg::hash_rsp_t hrsp;

  hflp_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  logic [CW-1:0] limit;
  logic [AW-1:0] home;
  logic [AW-1:0] d_ideal, d_gap;

  always_comb begin
    if ({1'b0, max_fill_q} >= 10'(SLOTS)) limit = CW'(SLOTS);
    else limit = CW'(max_fill_q);
    home = hrsp.hash[AW-1:0];
    d_ideal = look_q - home;
    d_gap = look_q - gap_q;
  end

  always_ff @(posedge clk_i) begin
    if (kw_en) key_mem[kw_addr] <= kw_data;
    if (pw_en) prv_mem[pw_addr] <= pw_data;
    if (nw_en) nxt_mem[nw_addr] <= nw_data;
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      prv_rd <= prv_mem[rd_addr];
      nxt_rd <= nxt_mem[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    id_d = id_q;
    s_d = s_q;
    gap_d = gap_q;
    look_d = look_q;
    n_d = n_q;
    cnt_d = cnt_q;
    old_d = old_q;
    new_d = new_q;
    mkey_d = mkey_q;
    mprv_d = mprv_q;
    mnxt_d = mnxt_q;
    used_d = used_q;
    rsp_d = rsp_q;
    done_d = 1'b0;
    rd_en = 1'b0;
    rd_addr = s_q;
    kw_en = 1'b0; kw_addr = s_q; kw_data = id_q;
    pw_en = 1'b0; pw_addr = s_q; pw_data = '0;
    nw_en = 1'b0; nw_addr = s_q; nw_data = '0;
    hreq.start = 1'b0;
    hreq.key = id_q;
    hreq.mode = hash_mode_q;

    case (state_q)
      hflp_pkg::S_IDLE: begin
        if (start_i) begin
          req_d = req_i.req_type;
          id_d = req_i.item_id;
          rsp_d = '0;
          state_d = hflp_pkg::S_HASH;
        end
      end
      hflp_pkg::S_HASH: begin
        state_d = hflp_pkg::S_DONE;
        rsp_d.entry_count = 9'(cnt_q);
        case (req_q)
          hflp_pkg::REQ_ENQ: begin
            if (cnt_q >= limit) rsp_d.status = hflp_pkg::ST_FULL;
            else begin
              hreq.start = 1'b1;
              state_d = hflp_pkg::S_HASH_W;
            end
          end
          hflp_pkg::REQ_DEQ: begin
            if (cnt_q == '0) rsp_d.status = hflp_pkg::ST_EMPTY;
            else begin
              s_d = old_q;
              state_d = hflp_pkg::S_DEQ_RD;
            end
          end
          default: begin
            if (cnt_q == '0) rsp_d.status = hflp_pkg::ST_NOTFOUND;
            else begin
              hreq.start = 1'b1;
              state_d = hflp_pkg::S_HASH_W;
            end
          end
        endcase
      end
      hflp_pkg::S_HASH_W: begin
        if (hrsp.done) begin
          s_d = home;
          n_d = '0;
          state_d = hflp_pkg::S_PROBE_RD;
        end
      end
      hflp_pkg::S_PROBE_RD: begin
        if (req_q == hflp_pkg::REQ_ENQ) begin
          if (used_q[s_q]) s_d = s_q + AW'(1);
          else state_d = hflp_pkg::S_ENQ_WR;
        end else if (n_q == CW'(SLOTS) || !used_q[s_q]) begin
          rsp_d.status = hflp_pkg::ST_NOTFOUND;
          state_d = hflp_pkg::S_DONE;
        end else begin
          rd_en = 1'b1;
          state_d = hflp_pkg::S_PROBE;
        end
      end
      hflp_pkg::S_PROBE: begin
        if (key_rd == id_q) begin
          rsp_d.result_id = id_q;
          rsp_d.slot_index = 8'(s_q);
          if (req_q == hflp_pkg::REQ_LOOK) state_d = hflp_pkg::S_DONE;
          else begin
            rd_en = 1'b1;
            state_d = hflp_pkg::S_UNLINK;
          end
        end else begin
          s_d = s_q + AW'(1);
          n_d = n_q + CW'(1);
          state_d = hflp_pkg::S_PROBE_RD;
        end
      end
      hflp_pkg::S_ENQ_WR: begin
        kw_en = 1'b1;
        nw_en = 1'b1;
        pw_en = 1'b1;
        pw_data = (cnt_q == '0) ? '0 : new_q;
        used_d[s_q] = 1'b1;
        if (cnt_q == '0) old_d = s_q;
        state_d = hflp_pkg::S_ENQ_LINK;
      end
      hflp_pkg::S_ENQ_LINK: begin
        if (cnt_q != '0) begin
          nw_en = 1'b1;
          nw_addr = new_q;
          nw_data = s_q;
        end
        new_d = s_q;
        cnt_d = cnt_q + CW'(1);
        rsp_d.slot_index = 8'(s_q);
        rsp_d.entry_count = 9'(cnt_q + CW'(1));
        state_d = hflp_pkg::S_DONE;
      end
      hflp_pkg::S_DEQ_RD: begin
        rd_en = 1'b1;
        state_d = hflp_pkg::S_DEQ_KEY;
      end
      hflp_pkg::S_DEQ_KEY: begin
        rsp_d.result_id = key_rd;
        rsp_d.slot_index = 8'(s_q);
        state_d = hflp_pkg::S_UNLINK;
      end
      hflp_pkg::S_UNLINK: begin
        // Read data holds prev/next of the removed slot.
        if (cnt_q <= CW'(1)) begin
          old_d = '0;
          new_d = '0;
          state_d = hflp_pkg::S_UNLINK2;
        end else if (s_q == old_q) begin
          old_d = nxt_rd;
          state_d = hflp_pkg::S_UNLINK2;
        end else if (s_q == new_q) begin
          new_d = prv_rd;
          nw_en = 1'b1;
          nw_addr = prv_rd;
          nw_data = '0;
          state_d = hflp_pkg::S_UNLINK2;
        end else begin
          nw_en = 1'b1;
          nw_addr = prv_rd;
          nw_data = nxt_rd;
          mprv_d = prv_rd;
          mnxt_d = nxt_rd;
          state_d = hflp_pkg::S_UNLINK_RD;
        end
      end
      hflp_pkg::S_UNLINK_RD: begin
        pw_en = 1'b1;
        pw_addr = mnxt_q;
        pw_data = mprv_q;
        state_d = hflp_pkg::S_UNLINK2;
      end
      hflp_pkg::S_UNLINK2: begin
        used_d[s_q] = 1'b0;
        cnt_d = cnt_q - CW'(1);
        gap_d = s_q;
        look_d = s_q + AW'(1);
        n_d = '0;
        state_d = hflp_pkg::S_SH_RD;
      end
      hflp_pkg::S_SH_RD: begin
        if (n_q == CW'(SLOTS) || !used_q[look_q]) begin
          rsp_d.entry_count = 9'(cnt_q);
          state_d = hflp_pkg::S_DONE;
        end else begin
          rd_en = 1'b1;
          rd_addr = look_q;
          state_d = hflp_pkg::S_SH_KEY;
        end
      end
      hflp_pkg::S_SH_KEY: begin
        mkey_d = key_rd;
        mprv_d = prv_rd;
        mnxt_d = nxt_rd;
        state_d = hflp_pkg::S_SH_HASH;
      end
      hflp_pkg::S_SH_HASH: begin
        hreq.start = 1'b1;
        hreq.key = mkey_q;
        state_d = hflp_pkg::S_SH_HASH_W;
      end
      hflp_pkg::S_SH_HASH_W: begin
        if (hrsp.done) state_d = hflp_pkg::S_SH_TEST;
      end
      hflp_pkg::S_SH_TEST: begin
        if (d_ideal >= d_gap) state_d = hflp_pkg::S_SH_MOVE;
        else begin
          look_d = look_q + AW'(1);
          n_d = n_q + CW'(1);
          state_d = hflp_pkg::S_SH_RD;
        end
      end
      hflp_pkg::S_SH_MOVE: begin
        kw_en = 1'b1; kw_addr = gap_q; kw_data = mkey_q;
        pw_en = 1'b1; pw_addr = gap_q; pw_data = mprv_q;
        nw_en = 1'b1; nw_addr = gap_q; nw_data = mnxt_q;
        used_d[gap_q] = 1'b1;
        used_d[look_q] = 1'b0;
        state_d = hflp_pkg::S_SH_FIXP;
      end
      hflp_pkg::S_SH_FIXP: begin
        if (look_q == old_q) old_d = gap_q;
        else begin
          nw_en = 1'b1; nw_addr = mprv_q; nw_data = gap_q;
        end
        state_d = hflp_pkg::S_SH_FIXN;
      end
      hflp_pkg::S_SH_FIXN: begin
        if (look_q == new_q) new_d = gap_q;
        else begin
          pw_en = 1'b1; pw_addr = mnxt_q; pw_data = gap_q;
        end
        gap_d = look_q;
        look_d = look_q + AW'(1);
        n_d = n_q + CW'(1);
        state_d = hflp_pkg::S_SH_RD;
      end
      hflp_pkg::S_DONE: begin
        done_d = 1'b1;
        state_d = hflp_pkg::S_IDLE;
      end
      default: state_d = hflp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hflp_pkg::S_IDLE;
      used_q <= '0;
      cnt_q <= '0;
      old_q <= '0;
      new_q <= '0;
      done_q <= 1'b0;
      hash_mode_q <= 1'b1;
      max_fill_q <= 9'd192;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      cnt_q <= cnt_d;
      old_q <= old_d;
      new_q <= new_d;
      done_q <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == hflp_pkg::CFG_HASH_MODE) hash_mode_q <= cfg_data_i[0];
        else max_fill_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    id_q <= id_d;
    s_q <= s_d;
    gap_q <= gap_d;
    look_q <= look_d;
    n_q <= n_d;
    mkey_q <= mkey_d;
    mprv_q <= mprv_d;
    mnxt_q <= mnxt_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != hflp_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS)) else $error("entry count above table size");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == hflp_pkg::S_IDLE) else $error("result while busy");
  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hflp_pkg::S_IDLE |-> $countones(used_q) == int'(cnt_q))
    else $error("used flags disagree with count");
`endif

endmodule
